// ----- hw/rtl/lomb_pkg.sv -----
// shared types, codes and default sizes for the limit order matching book
// no dependencies; imported by every module of the block
package lomb_pkg;

    localparam int DEF_PRICE_LEVELS    = 32;
    localparam int DEF_SLOTS_PER_LEVEL = 8;

    localparam int ID_W    = 31;
    localparam int QTY_W   = 24;
    localparam int PRICE_W = 5;
    localparam int ENTRY_W = ID_W + QTY_W;
    localparam int TDATA_W = 64;

    typedef enum logic [2:0] {
        KIND_FILL      = 3'd0,
        KIND_RESTED    = 3'd1,
        KIND_CANCELLED = 3'd2,
        KIND_NOT_FOUND = 3'd3,
        KIND_REJECTED  = 3'd4
    } kind_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_LVL,
        S_HUSE,
        S_SH,
        S_SHWR,
        S_LCONT,
        S_LEND,
        S_REST,
        S_CCHK,
        S_CCMP,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic               valid;
        kind_t              kind;
        logic [ID_W-1:0]    id;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
        logic               last;
    } emit_t;

    typedef struct packed {
        logic             h_gt_q;
        logic [QTY_W-1:0] h_minus_q;
        logic [QTY_W-1:0] q_minus_h;
        logic [QTY_W-1:0] fill_sum;
    } alu_res_t;

endpackage

// ----- hw/rtl/lomb_mem.sv -----
// resting order entry memory, one write and one registered read port
// depends on lomb_pkg for the entry width
module lomb_mem
    import lomb_pkg::*;
#(
    parameter int AW = 9
) (
    input  logic               clk,
    input  logic               we,
    input  logic [AW-1:0]      waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic               re,
    input  logic [AW-1:0]      raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0] mem [2**AW];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/lomb_alu.sv -----
// shared quantity unit: head versus remaining compare, differences, fill sum
// depends on lomb_pkg for alu_res_t
module lomb_alu
    import lomb_pkg::*;
(
    input  logic [QTY_W-1:0] q,
    input  logic [QTY_W-1:0] h,
    input  logic [QTY_W-1:0] fill,
    output alu_res_t         res
);

    always_comb
    begin
        res.h_gt_q    = h > q;
        res.h_minus_q = h - q;
        res.q_minus_h = q - h;
        res.fill_sum  = fill + (res.h_gt_q ? q : h);
    end

endmodule

// ----- hw/rtl/lomb_seq.sv -----
// sequencer of the book: level walk, head fills, slot shifts, cancel search
// depends on lomb_pkg, lomb_mem and lomb_alu
module lomb_seq
    import lomb_pkg::*;
#(
    parameter int PRICE_LEVELS    = DEF_PRICE_LEVELS,
    parameter int SLOTS_PER_LEVEL = DEF_SLOTS_PER_LEVEL
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               in_op,
    input  logic [ID_W-1:0]    in_id,
    input  logic               in_sell,
    input  logic [QTY_W-1:0]   in_qty,
    input  logic [PRICE_W-1:0] in_price,
    input  logic               out_free,
    output emit_t              emit
);

    localparam int LW = (PRICE_LEVELS > 1) ? $clog2(PRICE_LEVELS) : 1;
    localparam int SW = (SLOTS_PER_LEVEL > 1) ? $clog2(SLOTS_PER_LEVEL) : 1;
    localparam int CW = $clog2(SLOTS_PER_LEVEL + 1);
    localparam int AW = 1 + LW + SW;

    state_t state_reg, state_next;

    logic [LW-1:0]      lvl_reg, lvl_next;
    logic [CW-1:0]      k_reg, k_next;
    logic [QTY_W-1:0]   q_reg, q_next;
    logic [QTY_W-1:0]   fill_reg, fill_next;
    logic [ID_W-1:0]    id_reg, id_next;
    logic [PRICE_W-1:0] price_reg, price_next;
    logic               sell_reg, sell_next;
    logic               side_reg, side_next;
    logic               wend_reg, wend_next;
    logic               canc_reg, canc_next;
    kind_t              ekind_reg, ekind_next;
    logic [QTY_W-1:0]   eqty_reg, eqty_next;
    logic [PRICE_W-1:0] eprice_reg, eprice_next;
    logic               elast_reg, elast_next;

    logic [CW-1:0] cnt_reg [2][PRICE_LEVELS];
    logic          cnt_inc, cnt_dec;
    logic [CW-1:0] cur_cnt;

    logic               mem_we, mem_re;
    logic [AW-1:0]      mem_waddr, mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata, mem_rdata;
    logic [ID_W-1:0]    rd_id;
    logic [QTY_W-1:0]   rd_qty;
    alu_res_t           alu;

    logic          p_ok;
    logic          lvl_ok;
    logic [CW:0]   k_plus;
    logic          more_slots;
    logic [SW-1:0] k_idx, k1_idx;

    assign cur_cnt    = cnt_reg[side_reg][lvl_reg];
    assign rd_id      = mem_rdata[ID_W-1:0];
    assign rd_qty     = mem_rdata[ENTRY_W-1:ID_W];
    assign p_ok       = 7'(price_reg) < 7'(PRICE_LEVELS);
    assign lvl_ok     = sell_reg ? (7'(lvl_reg) >= 7'(price_reg))
                                 : (7'(lvl_reg) <= 7'(price_reg));
    assign k_plus     = (CW+1)'(k_reg) + (CW+1)'(1);
    assign more_slots = k_plus < (CW+1)'(cur_cnt);
    assign k_idx      = k_reg[SW-1:0];
    assign k1_idx     = k_plus[SW-1:0];
    assign in_ready   = (state_reg == S_IDLE);

    lomb_mem #(.AW(AW)) u_mem (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    lomb_alu u_alu (
        .q    (q_reg),
        .h    (rd_qty),
        .fill (fill_reg),
        .res  (alu)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_op)
                    begin
                        state_next = (7'(in_price) < 7'(PRICE_LEVELS)) ? S_CCHK : S_EMIT;
                    end
                    else if (in_qty == '0)
                    begin
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_LVL;
                    end
                end
            end
            S_LVL:
            begin
                if (!lvl_ok || wend_reg)
                begin
                    state_next = S_REST;
                end
                else if (cur_cnt != '0)
                begin
                    state_next = S_HUSE;
                end
            end
            S_HUSE:  state_next = alu.h_gt_q ? S_LEND : S_SH;
            S_SH:
            begin
                if (more_slots)
                begin
                    state_next = S_SHWR;
                end
                else
                begin
                    state_next = canc_reg ? S_EMIT : S_LCONT;
                end
            end
            S_SHWR:  state_next = S_SH;
            S_LCONT: state_next = (cur_cnt != '0 && q_reg != '0) ? S_HUSE : S_LEND;
            S_LEND:  state_next = S_EMIT;
            S_REST:  state_next = S_EMIT;
            S_CCHK:  state_next = (k_reg < cur_cnt) ? S_CCMP : S_EMIT;
            S_CCMP:  state_next = (rd_id == id_reg) ? S_SH : S_CCHK;
            S_EMIT:
            begin
                if (out_free)
                begin
                    state_next = elast_reg ? S_IDLE : S_LVL;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb
    begin
        lvl_next    = lvl_reg;
        k_next      = k_reg;
        q_next      = q_reg;
        fill_next   = fill_reg;
        id_next     = id_reg;
        price_next  = price_reg;
        sell_next   = sell_reg;
        side_next   = side_reg;
        wend_next   = wend_reg;
        canc_next   = canc_reg;
        ekind_next  = ekind_reg;
        eqty_next   = eqty_reg;
        eprice_next = eprice_reg;
        elast_next  = elast_reg;
        cnt_inc     = 1'b0;
        cnt_dec     = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;
        mem_waddr   = {side_reg, lvl_reg, k_idx};
        mem_raddr   = {side_reg, lvl_reg, k_idx};
        mem_wdata   = mem_rdata;
        emit.valid  = 1'b0;
        emit.kind   = ekind_reg;
        emit.id     = id_reg;
        emit.qty    = eqty_reg;
        emit.price  = eprice_reg;
        emit.last   = elast_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    id_next     = in_id;
                    price_next  = in_price;
                    sell_next   = in_sell;
                    q_next      = in_qty;
                    fill_next   = '0;
                    k_next      = '0;
                    wend_next   = 1'b0;
                    canc_next   = in_op;
                    eprice_next = in_price;
                    eqty_next   = '0;
                    elast_next  = 1'b1;
                    if (in_op)
                    begin
                        side_next  = in_sell;
                        lvl_next   = LW'(in_price);
                        ekind_next = KIND_NOT_FOUND;
                    end
                    else
                    begin
                        ekind_next = KIND_REJECTED;
                        side_next  = !in_sell;
                        lvl_next   = in_sell ? LW'(PRICE_LEVELS - 1) : '0;
                    end
                end
            end
            S_LVL:
            begin
                if (!lvl_ok || wend_reg)
                begin
                    side_next = sell_reg;
                    lvl_next  = LW'(price_reg);
                end
                else if (cur_cnt != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {side_reg, lvl_reg, {SW{1'b0}}};
                end
                else if (sell_reg)
                begin
                    if (lvl_reg == '0)
                        wend_next = 1'b1;
                    else
                        lvl_next = lvl_reg - LW'(1);
                end
                else
                begin
                    if (lvl_reg == LW'(PRICE_LEVELS - 1))
                        wend_next = 1'b1;
                    else
                        lvl_next = lvl_reg + LW'(1);
                end
            end
            S_HUSE:
            begin
                fill_next = alu.fill_sum;
                k_next    = '0;
                if (alu.h_gt_q)
                begin
                    q_next    = '0;
                    mem_we    = 1'b1;
                    mem_waddr = {side_reg, lvl_reg, {SW{1'b0}}};
                    mem_wdata = {alu.h_minus_q, rd_id};
                end
                else
                begin
                    q_next = alu.q_minus_h;
                end
            end
            S_SH:
            begin
                if (more_slots)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {side_reg, lvl_reg, k1_idx};
                end
                else
                begin
                    cnt_dec = 1'b1;
                    if (canc_reg)
                    begin
                        ekind_next = KIND_CANCELLED;
                        eqty_next  = fill_reg;
                    end
                end
            end
            S_SHWR:
            begin
                mem_we    = 1'b1;
                mem_waddr = {side_reg, lvl_reg, k_idx};
                k_next    = k_plus[CW-1:0];
            end
            S_LCONT:
            begin
                if (cur_cnt != '0 && q_reg != '0)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {side_reg, lvl_reg, {SW{1'b0}}};
                end
            end
            S_LEND:
            begin
                // a fill is final exactly when nothing remains
                ekind_next  = KIND_FILL;
                eqty_next   = fill_reg;
                eprice_next = PRICE_W'(lvl_reg);
                elast_next  = (q_reg == '0);
                fill_next   = '0;
                if (sell_reg)
                begin
                    if (lvl_reg == '0)
                        wend_next = 1'b1;
                    else
                        lvl_next = lvl_reg - LW'(1);
                end
                else
                begin
                    if (lvl_reg == LW'(PRICE_LEVELS - 1))
                        wend_next = 1'b1;
                    else
                        lvl_next = lvl_reg + LW'(1);
                end
            end
            S_REST:
            begin
                eqty_next   = q_reg;
                eprice_next = price_reg;
                elast_next  = 1'b1;
                if (p_ok && cur_cnt < CW'(SLOTS_PER_LEVEL))
                begin
                    ekind_next = KIND_RESTED;
                    cnt_inc    = 1'b1;
                    mem_we     = 1'b1;
                    mem_waddr  = {side_reg, lvl_reg, cur_cnt[SW-1:0]};
                    mem_wdata  = {q_reg, id_reg};
                end
                else
                begin
                    ekind_next = KIND_REJECTED;
                end
            end
            S_CCHK:
            begin
                if (k_reg < cur_cnt)
                begin
                    mem_re    = 1'b1;
                    mem_raddr = {side_reg, lvl_reg, k_idx};
                end
            end
            S_CCMP:
            begin
                if (rd_id == id_reg)
                begin
                    fill_next = rd_qty;
                end
                else
                begin
                    k_next = k_plus[CW-1:0];
                end
            end
            S_EMIT:
            begin
                emit.valid = out_free;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            for (int s = 0; s < 2; s++)
            begin
                for (int l = 0; l < PRICE_LEVELS; l++)
                begin
                    cnt_reg[s][l] <= '0;
                end
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cnt_inc)
            begin
                cnt_reg[side_reg][lvl_reg] <= cur_cnt + CW'(1);
            end
            else if (cnt_dec)
            begin
                cnt_reg[side_reg][lvl_reg] <= cur_cnt - CW'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        lvl_reg    <= lvl_next;
        k_reg      <= k_next;
        q_reg      <= q_next;
        fill_reg   <= fill_next;
        id_reg     <= id_next;
        price_reg  <= price_next;
        sell_reg   <= sell_next;
        side_reg   <= side_next;
        wend_reg   <= wend_next;
        canc_reg   <= canc_next;
        ekind_reg  <= ekind_next;
        eqty_reg   <= eqty_next;
        eprice_reg <= eprice_next;
        elast_reg  <= elast_next;
    end

endmodule

// ----- hw/rtl/limit_order_matching_book.sv -----
// top level of the limit order matching book: stream ports and output register
// depends on lomb_pkg and lomb_seq
//
// channel   dir  tdata bits (low first)                      tuser / tlast
// s_axis    in   order_id[30:0] quantity[54:31] price[59:55]  op[0] is_sell[1]
// m_axis    out  order_id_res[30:0] result_quantity[54:31]
//                result_price[59:55]                          kind[2:0], last
//
// one word at a time: s_axis_tready is high only while the sequencer is idle
// a place is accepted, then walks the levels inside its limit; at a level with fills each
// resting order touched is read and used, each removal shifts the later slots down, and the
// level ends in its fill word; a remainder then gets a stop check, its rest or reject and
// its result word. a cancel reads its slots in turn until the id matches or none are left,
// shifts any later slots down and ends in its result word; a stalled m_axis holds the result state
// reset clears the level counts at once; no clearing pass
module limit_order_matching_book
    import lomb_pkg::*;
#(
    parameter int PRICE_LEVELS    = DEF_PRICE_LEVELS,
    parameter int SLOTS_PER_LEVEL = DEF_SLOTS_PER_LEVEL
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_axis_tvalid,
    output logic               s_axis_tready,
    input  logic [TDATA_W-1:0] s_axis_tdata,   // order_id, quantity, price
    input  logic [1:0]         s_axis_tuser,   // op, is_sell
    output logic               m_axis_tvalid,
    input  logic               m_axis_tready,
    output logic [TDATA_W-1:0] m_axis_tdata,   // order_id_res, result_quantity, result_price
    output logic [2:0]         m_axis_tuser,   // kind
    output logic               m_axis_tlast    // last
);

    emit_t emit;
    logic  out_free;

    logic               out_valid_reg;
    logic [TDATA_W-1:0] out_data_reg;
    logic [2:0]         out_kind_reg;
    logic               out_last_reg;

    // output register is free when empty or being taken this cycle
    assign out_free = !out_valid_reg || m_axis_tready;

    lomb_seq #(
        .PRICE_LEVELS    (PRICE_LEVELS),
        .SLOTS_PER_LEVEL (SLOTS_PER_LEVEL)
    ) u_seq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .in_op    (s_axis_tuser[0]),
        .in_id    (s_axis_tdata[ID_W-1:0]),
        .in_sell  (s_axis_tuser[1]),
        .in_qty   (s_axis_tdata[ID_W+QTY_W-1:ID_W]),
        .in_price (s_axis_tdata[ENTRY_W+PRICE_W-1:ENTRY_W]),
        .out_free (out_free),
        .emit     (emit)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit.valid)
        begin
            out_data_reg <= {{(TDATA_W-ENTRY_W-PRICE_W){1'b0}}, emit.price, emit.qty, emit.id};
            out_kind_reg <= emit.kind;
            out_last_reg <= emit.last;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tlast  = out_last_reg;

endmodule

// ----- hw/rtl/lomb_checker.sv -----
// port level checks for the limit order matching book, bound to the top level
// depends on lomb_pkg for the result kind codes
module lomb_checker
    import lomb_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               s_axis_tvalid,
    input logic               s_axis_tready,
    input logic               m_axis_tvalid,
    input logic               m_axis_tready,
    input logic [TDATA_W-1:0] m_axis_tdata,
    input logic [2:0]         m_axis_tuser,
    input logic               m_axis_tlast
);

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)
            && $stable(m_axis_tlast))
        else $error("result word changed while stalled");

    // a new word is never taken right after one was accepted
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready right after accept");

    // a fill always moves shares
    a_fill_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser == KIND_FILL |->
            m_axis_tdata[ID_W+QTY_W-1:ID_W] != '0)
        else $error("fill with zero quantity");

    // rest, cancel and not found results close their word
    a_final_kinds: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser == KIND_RESTED || m_axis_tuser == KIND_CANCELLED
            || m_axis_tuser == KIND_NOT_FOUND) |-> m_axis_tlast)
        else $error("closing result kind without last");

endmodule

bind limit_order_matching_book lomb_checker u_lomb_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// ----- tb/tb_limit_order_matching_book.sv -----
// self-checking bench for the limit order matching book: directed table, then random traffic
// depends on lomb_pkg and limit_order_matching_book; predicts results with its own book model
module tb_limit_order_matching_book;
    import lomb_pkg::*;

    localparam int LEVELS    = DEF_PRICE_LEVELS;
    localparam int SLOTS     = DEF_SLOTS_PER_LEVEL;
    localparam int N_RANDOM  = 350;
    localparam int IDLE_STOP = 20000;

    localparam logic OP_PLACE  = 1'b0;
    localparam logic OP_CANCEL = 1'b1;
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    typedef struct {
        logic               op;
        logic [ID_W-1:0]    id;
        logic               sell;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
    } order_t;

    typedef struct packed {
        kind_t              kind;
        logic [ID_W-1:0]    id;
        logic [QTY_W-1:0]   qty;
        logic [PRICE_W-1:0] price;
        logic               last;
    } report_t;

    // directed row: order plus an optional typed-in last report
    typedef struct {
        order_t  ord;
        logic    has_report;
        report_t report;
    } row_t;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic [1:0]         s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [2:0]         m_axis_tuser;
    logic               m_axis_tlast;

    limit_order_matching_book i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // book mirror: [side][level][slot], side 0 bids, side 1 asks
    logic [ID_W-1:0]  book_id  [2][LEVELS][SLOTS];
    logic [QTY_W-1:0] book_qty [2][LEVELS][SLOTS];
    int               book_cnt [2][LEVELS];

    report_t pending_reports[$];
    row_t    rows[$];
    int      errors;
    int      idle_cycles;
    bit      stim_done;
    bit      hold_off;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void push_report(kind_t k, logic [ID_W-1:0] id,
                                        logic [QTY_W-1:0] q, logic [PRICE_W-1:0] p);
        report_t r;
        r.kind  = k;
        r.id    = id;
        r.qty   = q;
        r.price = p;
        r.last  = 1'b0;
        pending_reports = {pending_reports, r};
    endfunction

    function automatic void drop_slot(int s, int lvl, int k);
        for (int i = k; i + 1 < book_cnt[s][lvl]; i++)
        begin
            book_id[s][lvl][i]  = book_id[s][lvl][i+1];
            book_qty[s][lvl][i] = book_qty[s][lvl][i+1];
        end
        book_cnt[s][lvl]--;
    endfunction

    // take from the oldest resting orders of one level
    function automatic void fill_level(int s, int lvl, ref logic [QTY_W-1:0] q,
                                       input logic [ID_W-1:0] id);
        logic [QTY_W-1:0] filled;
        filled = '0;
        while (book_cnt[s][lvl] > 0 && q > 0)
        begin
            if (book_qty[s][lvl][0] > q)
            begin
                book_qty[s][lvl][0] -= q;
                filled += q;
                q = '0;
            end
            else
            begin
                filled += book_qty[s][lvl][0];
                q -= book_qty[s][lvl][0];
                drop_slot(s, lvl, 0);
            end
        end
        if (filled > 0)
            push_report(KIND_FILL, id, filled, PRICE_W'(lvl));
    endfunction

    // predicts the reports of one accepted order and updates the mirror
    function automatic void predict_book(order_t o);
        logic [QTY_W-1:0] q;
        int s;
        int p;
        bit found;
        q = o.qty;
        s = int'(o.sell);
        p = int'(o.price);
        found = 1'b0;
        if (o.op == OP_CANCEL)
        begin
            if (p < LEVELS)
                for (int k = 0; k < book_cnt[s][p] && !found; k++)
                    if (book_id[s][p][k] == o.id)
                    begin
                        push_report(KIND_CANCELLED, o.id, book_qty[s][p][k], o.price);
                        drop_slot(s, p, k);
                        found = 1'b1;
                    end
            if (!found)
                push_report(KIND_NOT_FOUND, o.id, '0, o.price);
        end
        else if (q == 0)
            push_report(KIND_REJECTED, o.id, '0, o.price);
        else
        begin
            if (o.sell == SIDE_BUY)
            begin
                for (int lvl = 0; lvl < LEVELS && lvl <= p && q > 0; lvl++)
                    fill_level(1, lvl, q, o.id);
            end
            else
            begin
                for (int lvl = LEVELS - 1; lvl >= p && q > 0; lvl--)
                    fill_level(0, lvl, q, o.id);
            end
            if (q > 0)
            begin
                if (p < LEVELS && book_cnt[s][p] < SLOTS)
                begin
                    book_id[s][p][book_cnt[s][p]]  = o.id;
                    book_qty[s][p][book_cnt[s][p]] = q;
                    book_cnt[s][p]++;
                    push_report(KIND_RESTED, o.id, q, o.price);
                end
                else
                    push_report(KIND_REJECTED, o.id, q, o.price);
            end
        end
        pending_reports[$].last = 1'b1;
    endfunction

    function automatic order_t mk_order(logic op, logic [ID_W-1:0] id, logic sell,
                                        logic [QTY_W-1:0] q, logic [PRICE_W-1:0] p);
        order_t o;
        o.op    = op;
        o.id    = id;
        o.sell  = sell;
        o.qty   = q;
        o.price = p;
        return o;
    endfunction

    function automatic void add_row(order_t o, logic chk = 1'b0, kind_t k = KIND_FILL,
                                    logic [QTY_W-1:0] q = '0, logic [PRICE_W-1:0] p = '0,
                                    logic l = 1'b1);
        row_t r;
        r.ord             = o;
        r.has_report      = chk;
        r.report.kind     = k;
        r.report.id       = o.id;
        r.report.qty      = q;
        r.report.price    = p;
        r.report.last     = l;
        rows = {rows, r};
    endfunction

    // directed rows: extremes, every kind, the special cases
    function automatic void build_table();
        localparam logic [ID_W-1:0]  ID_MAX  = '1;
        localparam logic [QTY_W-1:0] QTY_MAX = '1;
        // empty book: cancel finds nothing
        add_row(mk_order(OP_CANCEL, 31'd5, SIDE_BUY, '0, 5'd3),
                1'b1, KIND_NOT_FOUND, '0, 5'd3);
        // zero quantity place is rejected with quantity 0
        add_row(mk_order(OP_PLACE, ID_MAX, SIDE_SELL, '0, 5'd31),
                1'b1, KIND_REJECTED, '0, 5'd31);
        // extremes rest on an empty book
        add_row(mk_order(OP_PLACE, ID_MAX, SIDE_SELL, QTY_MAX, 5'd31),
                1'b1, KIND_RESTED, QTY_MAX, 5'd31);
        add_row(mk_order(OP_PLACE, 31'd0, SIDE_BUY, 24'd1, 5'd0),
                1'b1, KIND_RESTED, 24'd1, 5'd0);
        add_row(mk_order(OP_PLACE, 31'd10, SIDE_SELL, 24'd100, 5'd10));
        add_row(mk_order(OP_PLACE, 31'd11, SIDE_SELL, 24'd50, 5'd10));
        add_row(mk_order(OP_PLACE, 31'd12, SIDE_SELL, 24'd70, 5'd12));
        // buy sweeps two levels and rests the remainder
        add_row(mk_order(OP_PLACE, 31'd20, SIDE_BUY, 24'd300, 5'd12));
        // duplicate ids, cancel takes the oldest
        add_row(mk_order(OP_PLACE, 31'd30, SIDE_BUY, 24'd7, 5'd5));
        add_row(mk_order(OP_PLACE, 31'd30, SIDE_BUY, 24'd9, 5'd5));
        add_row(mk_order(OP_CANCEL, 31'd30, SIDE_BUY, '0, 5'd5),
                1'b1, KIND_CANCELLED, 24'd7, 5'd5);
        add_row(mk_order(OP_CANCEL, 31'd30, SIDE_SELL, QTY_MAX, 5'd5),
                1'b1, KIND_NOT_FOUND, '0, 5'd5);
        // fill a level, then overflow it: a place on the full level is rejected
        for (int i = 0; i < SLOTS - 1; i++)
            add_row(mk_order(OP_PLACE, 31'(40 + i), SIDE_BUY, 24'd2, 5'd5));
        add_row(mk_order(OP_PLACE, 31'd50, SIDE_SELL, 24'd1, 5'd20));
        add_row(mk_order(OP_PLACE, 31'd51, SIDE_BUY, 24'd5, 5'd20));
        add_row(mk_order(OP_PLACE, 31'd52, SIDE_BUY, 24'd3, 5'd5),
                1'b1, KIND_REJECTED, 24'd3, 5'd5);
        // sell walks bids down to its limit
        add_row(mk_order(OP_PLACE, 31'd60, SIDE_SELL, 24'd40, 5'd0));
    endfunction

    function automatic order_t rand_order();
        order_t o;
        int pick;
        pick = $urandom_range(0, 99);
        o.id    = (pick < 90) ? ID_W'($urandom_range(0, 63)) : ID_W'($urandom);
        o.sell  = 1'($urandom_range(0, 1));
        o.price = (pick < 95) ? PRICE_W'($urandom_range(8, 23)) : PRICE_W'($urandom);
        if (pick < 75)
            o.qty = QTY_W'($urandom_range(1, 200));
        else if (pick < 97)
            o.qty = QTY_W'($urandom);
        else
            o.qty = '0;
        o.op = ($urandom_range(0, 3) == 0) ? OP_CANCEL : OP_PLACE;
        return o;
    endfunction

    // valid drops only for a gap, so back to back words keep it high
    task automatic send_order(order_t o);
        int gap;
        gap = $urandom_range(0, 15);
        if ($urandom_range(0, 3) == 0)
            gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {4'b0, o.price, o.qty, o.id};
        s_axis_tuser  <= {o.sell, o.op};
        do
            @(posedge clk);
        while (!s_axis_tready);
        predict_book(o);
    endtask

    // stimulus
    initial
    begin
        order_t o;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        errors        = 0;
        stim_done     = 1'b0;
        foreach (book_cnt[s, l])
            book_cnt[s][l] = 0;
        build_table();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (rows[i])
        begin
            send_order(rows[i].ord);
            // typed-in report must agree with the predictor
            if (rows[i].has_report && pending_reports[$] != rows[i].report)
            begin
                $display("%0t table row %0d: expected kind %0d qty %0d price %0d last %0b",
                         $time, i, rows[i].report.kind, rows[i].report.qty,
                         rows[i].report.price, rows[i].report.last);
                $display("%0t              actual   kind %0d qty %0d price %0d last %0b",
                         $time, pending_reports[$].kind, pending_reports[$].qty,
                         pending_reports[$].price, pending_reports[$].last);
                errors++;
            end
        end
        for (int n = 0; n < N_RANDOM; n++)
        begin
            o = rand_order();
            send_order(o);
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver: random stall per word, and one long hold-off
    initial
    begin
        int wait_n;
        m_axis_tready = 1'b0;
        hold_off      = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (wait_n > 0)
            begin
                wait_n--;
                m_axis_tready <= 1'b0;
            end
            else if (m_axis_tready && m_axis_tvalid)
            begin
                wait_n = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 15);
                if (!hold_off && $time > 2000)
                begin
                    hold_off = 1'b1;
                    wait_n   = 400;   // long stall, sender keeps offering
                end
                m_axis_tready <= (wait_n == 0);
            end
            else
                m_axis_tready <= 1'b1;
        end
    end

    // output check
    always @(posedge clk)
    begin
        report_t got;
        report_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.kind  = kind_t'(m_axis_tuser);
            got.id    = m_axis_tdata[ID_W-1:0];
            got.qty   = m_axis_tdata[ID_W +: QTY_W];
            got.price = m_axis_tdata[ID_W+QTY_W +: PRICE_W];
            got.last  = m_axis_tlast;
            if (pending_reports.size() == 0)
            begin
                $display("%0t unexpected word: kind %0d id %0d qty %0d price %0d last %0b",
                         $time, got.kind, got.id, got.qty, got.price, got.last);
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (got != want)
                begin
                    $display("%0t mismatch: expected kind %0d id %0d qty %0d price %0d last %0b",
                             $time, want.kind, want.id, want.qty, want.price, want.last);
                    $display("%0t           actual   kind %0d id %0d qty %0d price %0d last %0b",
                             $time, got.kind, got.id, got.qty, got.price, got.last);
                    errors++;
                end
            end
        end
    end

    // watchdog and end of run
    initial
    begin
        idle_cycles = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_STOP)
            begin
                $display("CHECK FAILED");
                $finish;
            end
            if (stim_done && pending_reports.size() == 0)
            begin
                repeat (100) @(posedge clk);
                if (errors == 0 && pending_reports.size() == 0)
                    $display("CHECK OK");
                else
                    $display("CHECK FAILED");
                $finish;
            end
        end
    end

endmodule
